// ===== sv/hinge_loss_exact_line_search_core_assert.svh =====
// Assertion macros for the hinge-loss line search core.
`ifndef HINGE_LOSS_EXACT_LINE_SEARCH_CORE_ASSERT_SVH
`define HINGE_LOSS_EXACT_LINE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLELS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HLELS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hlels_pkg.sv =====
// Shared types, constants and fixed-point helpers for the line search core.
`timescale 1ns / 1ps
package hlels_pkg;

    localparam int Q_W              = 32;
    localparam int IDX_W            = 6;
    localparam int REG_W            = 31;
    localparam int CFG_IDX_W        = 1;
    localparam int MAX_EXAMPLES_DEF = 64;
    localparam int DIV_W            = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_SCALE = 1'd1;

    localparam logic [REG_W-1:0] RST_LAMBDA     = 31'd65536;
    localparam logic [REG_W-1:0] RST_LOSS_SCALE = 31'd65536;

    localparam logic signed [Q_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] ONE_Q  = 32'sh0001_0000;

    // One stored example
    typedef struct packed {
        logic                  ind;
        logic signed [Q_W-1:0] delta;
        logic signed [Q_W-1:0] score;
    } t_ex_entry;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[Q_W-1:0];
    endfunction

    // Q16.16 result of a 64-bit product: floor shift then saturate
    function automatic logic signed [Q_W-1:0] qsat(input logic signed [63:0] p);
        return sat32(p >>> 16);
    endfunction

    // Saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

endpackage

// ===== sv/hlels_in_if.sv =====
// Input channel: weight pairs and examples.
`timescale 1ns / 1ps
interface hlels_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [hlels_pkg::Q_W-1:0]  dir_elem;
    logic signed [hlels_pkg::Q_W-1:0]  weight_elem;
    logic signed [hlels_pkg::Q_W-1:0]  score;
    logic signed [hlels_pkg::Q_W-1:0]  score_delta;
    logic                              indicator_in;
    logic                              last;

    modport source (output valid, func, dir_elem, weight_elem, score, score_delta,
                    indicator_in, last, input ready);
    modport sink   (input valid, func, dir_elem, weight_elem, score, score_delta,
                    indicator_in, last, output ready);
endinterface

// ===== sv/hlels_out_if.sv =====
// Output channel: one result per stored example.
`timescale 1ns / 1ps
interface hlels_out_if;
    logic                               valid;
    logic                               ready;
    logic [hlels_pkg::IDX_W-1:0]        example_index;
    logic                               indicator_out;
    logic signed [hlels_pkg::Q_W-1:0]   step_size;
    logic                               step_infinite;
    logic                               result_last;

    modport source (output valid, example_index, indicator_out, step_size,
                    step_infinite, result_last, input ready);
    modport sink   (input valid, example_index, indicator_out, step_size,
                    step_infinite, result_last, output ready);
endinterface

// ===== sv/hinge_loss_exact_line_search_core.sv =====
// Exact line search for a regularized hinge loss, Q16.16 fixed point.
//
//  channel   dir  handshake      carries
//  i_in      in   valid/ready    weight pair or example item
//  o_out     out  valid/ready    example index, indicator, step size
//  i_cfg_*   in   write enable   lambda and loss scale registers
//
// Weight and example items are taken one per cycle while the core is idle.
// The last example starts a search that holds i_in.ready low: a divide for each
// breakpoint example (one quotient bit a cycle), a sorted-insert shift for each
// larger entry, an indicator pass over the examples, the breakpoint walk, a final
// divide when the previous rho and h are both positive, and the result delivery.
// A stalled o_out holds delivery at the current result. Reset is synchronous.
`timescale 1ns / 1ps
`include "hinge_loss_exact_line_search_core_assert.svh"
module hinge_loss_exact_line_search_core #(
    parameter int MAX_EXAMPLES = hlels_pkg::MAX_EXAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hlels_in_if.sink                          i_in,
    hlels_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [hlels_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hlels_pkg::REG_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_EXAMPLES > 1) ? $clog2(MAX_EXAMPLES) : 1;
    localparam int CW = $clog2(MAX_EXAMPLES + 1);
    localparam int BW = AW + hlels_pkg::Q_W;
    localparam int DW = hlels_pkg::DIV_W;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_BK_RD   = 5'd1;
    localparam logic [4:0] ST_BK_CHK  = 5'd2;
    localparam logic [4:0] ST_DIV     = 5'd3;
    localparam logic [4:0] ST_BK_Q    = 5'd4;
    localparam logic [4:0] ST_INS_RD  = 5'd5;
    localparam logic [4:0] ST_INS_CMP = 5'd6;
    localparam logic [4:0] ST_BK_NEXT = 5'd7;
    localparam logic [4:0] ST_B       = 5'd8;
    localparam logic [4:0] ST_B2      = 5'd9;
    localparam logic [4:0] ST_H       = 5'd10;
    localparam logic [4:0] ST_H2      = 5'd11;
    localparam logic [4:0] ST_START   = 5'd12;
    localparam logic [4:0] ST_IN_RD   = 5'd13;
    localparam logic [4:0] ST_IN_MUL  = 5'd14;
    localparam logic [4:0] ST_IN_UPD  = 5'd15;
    localparam logic [4:0] ST_RHO     = 5'd16;
    localparam logic [4:0] ST_RHO2    = 5'd17;
    localparam logic [4:0] ST_W_CHK   = 5'd18;
    localparam logic [4:0] ST_W_HV    = 5'd19;
    localparam logic [4:0] ST_W_EX    = 5'd20;
    localparam logic [4:0] ST_W_UPD   = 5'd21;
    localparam logic [4:0] ST_W_NXT   = 5'd22;
    localparam logic [4:0] ST_W_SUP   = 5'd23;
    localparam logic [4:0] ST_W_SUP2  = 5'd24;
    localparam logic [4:0] ST_FIN     = 5'd25;
    localparam logic [4:0] ST_FIN2    = 5'd26;
    localparam logic [4:0] ST_OUT_RD  = 5'd27;
    localparam logic [4:0] ST_OUT_LD  = 5'd28;
    localparam logic [4:0] ST_OUT_WT  = 5'd29;

    // Control state
    logic [4:0]    r_state;
    logic [CW-1:0] r_count, r_j, r_nb, r_pos, r_i;
    logic          r_wv, r_final, r_inf, r_out_valid;
    logic [5:0]    r_dcnt;

    // Configuration and accumulators
    logic [hlels_pkg::REG_W-1:0] r_lambda, r_cscale;
    logic signed [63:0]          r_dot, r_norm, r_pw, r_pp, r_mul_p;

    // Datapath
    logic [DW-1:0]        r_dvd;
    logic [32:0]          r_rem;
    logic [31:0]          r_dvs;
    logic signed [31:0]   r_v, r_b, r_h, r_start, r_rho, r_sup, r_prev, r_eta, r_hv;
    logic signed [31:0]   r_f, r_d;
    logic                 r_ind;
    logic signed [38:0]   r_sum;
    logic [AW-1:0]        r_cidx, r_k;

    // Output register
    logic [hlels_pkg::IDX_W-1:0] r_o_idx;
    logic                        r_o_ind, r_o_inf, r_o_last;
    logic signed [31:0]          r_o_step;

    // Memories
    hlels_pkg::t_ex_entry r_ex_mem [MAX_EXAMPLES];
    hlels_pkg::t_ex_entry r_ex_rdata;
    logic [BW-1:0]        r_brk_mem [MAX_EXAMPLES];
    logic [BW-1:0]        r_brk_rdata;

    logic                 ex_we, brk_we;
    logic [AW-1:0]        ex_waddr, ex_raddr, brk_waddr, brk_raddr;
    hlels_pkg::t_ex_entry ex_wdata;
    logic [BW-1:0]        brk_wdata;

    logic in_fire, out_fire, last_j;
    logic [CW-1:0] pos_m1, i_p1;
    logic signed [31:0] brk_val;
    logic [AW-1:0] brk_idx;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign last_j   = (r_j + 1'b1) == r_count;
    assign pos_m1   = r_pos - 1'b1;
    assign i_p1     = r_i + 1'b1;
    assign brk_val  = r_brk_rdata[31:0];
    assign brk_idx  = r_brk_rdata[BW-1:32];

    // Breakpoint operands: (1 - f) and df magnitudes, sign agreement
    logic signed [33:0] num34;
    logic [33:0]        num_abs;
    logic [32:0]        d_abs;
    logic               bk_ok;
    assign num34   = 34'sd65536 - 34'(r_ex_rdata.score);
    assign num_abs = num34[33] ? -num34 : num34;
    assign d_abs   = r_ex_rdata.delta[31] ? -33'(r_ex_rdata.delta) : 33'(r_ex_rdata.delta);
    assign bk_ok   = (r_ex_rdata.delta != '0) && (num34 != '0)
                     && (num34[33] == r_ex_rdata.delta[31]);

    // Restoring divider step, one quotient bit a cycle
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [31:0] q_sat;
    assign rem_sh = {r_rem[31:0], r_dvd[DW-1]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};
    assign q_sat  = (|r_dvd[DW-1:31]) ? 32'h7FFF_FFFF : {1'b0, r_dvd[30:0]};

    // Indicator at the start point, rho and sup updates
    logic signed [48:0] init_t;
    logic               init_ind;
    logic signed [31:0] rho_init, sup_init, step_q, rho_step, sup_walk;
    assign init_t   = 49'(r_f) + 49'(r_mul_p >>> 16);
    assign init_ind = init_t < 49'sd65536;
    assign rho_init = hlels_pkg::sat32(64'(hlels_pkg::qsat(r_mul_p)) - 64'(r_b));
    assign sup_init = hlels_pkg::sat32(-64'(rho_init));
    assign step_q   = hlels_pkg::qsat(r_mul_p);
    assign rho_step = r_ind ? hlels_pkg::sat32(64'(r_rho) - 64'(step_q))
                            : hlels_pkg::sat32(64'(r_rho) + 64'(step_q));
    assign sup_walk = hlels_pkg::sat32(64'(hlels_pkg::qsat(r_mul_p)) - 64'(r_rho));

    // Shared multiplier operand select
    logic signed [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_B: begin
                mul_a = {1'b0, r_lambda};
                mul_b = hlels_pkg::qsat(r_dot);
            end
            ST_H: begin
                mul_a = {1'b0, r_lambda};
                mul_b = hlels_pkg::qsat(r_norm);
            end
            ST_IN_MUL: begin
                mul_a = r_start;
                mul_b = r_ex_rdata.delta;
            end
            ST_RHO: begin
                mul_a = {1'b0, r_cscale};
                mul_b = hlels_pkg::sat32(64'(r_sum));
            end
            ST_W_EX: begin
                mul_a = {1'b0, r_cscale};
                mul_b = r_ex_rdata.delta;
            end
            ST_W_SUP: begin
                mul_a = r_hv;
                mul_b = r_h;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Memory port control
    always_comb begin
        ex_we     = 1'b0;
        ex_waddr  = r_j[AW-1:0];
        ex_wdata  = {r_ind, r_d, r_f};
        ex_raddr  = r_j[AW-1:0];
        brk_we    = 1'b0;
        brk_waddr = r_pos[AW-1:0];
        brk_wdata = {r_cidx, r_v};
        brk_raddr = r_i[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                ex_we    = in_fire && i_in.func && (r_count < CW'(MAX_EXAMPLES));
                ex_waddr = r_count[AW-1:0];
                ex_wdata = {i_in.indicator_in, i_in.score_delta, i_in.score};
            end
            ST_IN_UPD: begin
                ex_we    = 1'b1;
                ex_wdata = {init_ind, r_d, r_f};
            end
            ST_W_UPD: begin
                ex_we     = 1'b1;
                ex_waddr  = r_k;
                ex_wdata  = {~r_ind, r_d, r_f};
                brk_raddr = i_p1[AW-1:0];
            end
            ST_W_HV, ST_W_NXT: begin
                ex_raddr = brk_idx;
            end
            ST_INS_RD: begin
                brk_we    = (r_pos == '0);
                brk_raddr = pos_m1[AW-1:0];
            end
            ST_INS_CMP: begin
                brk_we = 1'b1;
                if (brk_val > r_v) begin
                    brk_wdata = r_brk_rdata;
                end
            end
            ST_H2: begin
                brk_raddr = '0;
            end
            default: begin
                ex_we = 1'b0;
            end
        endcase
    end

    // Example store and sorted breakpoint store
    always_ff @(posedge i_clk) begin
        if (ex_we) begin
            r_ex_mem[ex_waddr] <= ex_wdata;
        end
        r_ex_rdata <= r_ex_mem[ex_raddr];
        if (brk_we) begin
            r_brk_mem[brk_waddr] <= brk_wdata;
        end
        r_brk_rdata <= r_brk_mem[brk_raddr];
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        r_mul_p <= mul_a * mul_b;
        if (in_fire && !i_in.func) begin
            r_pw <= i_in.dir_elem * i_in.weight_elem;
            r_pp <= i_in.dir_elem * i_in.dir_elem;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_nb        <= '0;
            r_j         <= '0;
            r_i         <= '0;
            r_pos       <= '0;
            r_wv        <= 1'b0;
            r_final     <= 1'b0;
            r_inf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_dot       <= '0;
            r_norm      <= '0;
            r_lambda    <= hlels_pkg::RST_LAMBDA;
            r_cscale    <= hlels_pkg::RST_LOSS_SCALE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hlels_pkg::REG_LAMBDA:     r_lambda <= i_cfg_data;
                    hlels_pkg::REG_LOSS_SCALE: r_cscale <= i_cfg_data;
                    default:                   r_lambda <= r_lambda;
                endcase
            end

            // Weight pair accumulate, in the cycle after the products are registered
            r_wv <= in_fire && !i_in.func;
            if (r_wv) begin
                r_dot  <= hlels_pkg::sat_add64(r_dot, r_pw);
                r_norm <= hlels_pkg::sat_add64(r_norm, r_pp);
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_in.func) begin
                        if (r_count < CW'(MAX_EXAMPLES)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_in.last) begin
                            r_j     <= '0;
                            r_nb    <= '0;
                            r_state <= ST_BK_RD;
                        end
                    end
                end
                ST_BK_RD: begin
                    r_state <= ST_BK_CHK;
                end
                ST_BK_CHK: begin
                    r_cidx <= r_j[AW-1:0];
                    if (bk_ok) begin
                        r_dvd   <= {num_abs[31:0], 16'h0};
                        r_rem   <= '0;
                        r_dvs   <= d_abs[31:0];
                        r_dcnt  <= 6'(DW - 1);
                        r_final <= 1'b0;
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_BK_NEXT;
                    end
                end
                ST_DIV: begin
                    r_rem  <= div_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                    r_dvd  <= {r_dvd[DW-2:0], div_ge};
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        r_state <= r_final ? ST_FIN2 : ST_BK_Q;
                    end
                end
                ST_BK_Q: begin
                    if (r_dvd == '0) begin
                        r_state <= ST_BK_NEXT;
                    end else begin
                        r_v     <= q_sat;
                        r_pos   <= r_nb;
                        r_state <= ST_INS_RD;
                    end
                end
                // Insertion: shift larger entries up until the slot is found
                ST_INS_RD: begin
                    if (r_pos == '0) begin
                        r_nb    <= r_nb + 1'b1;
                        r_state <= ST_BK_NEXT;
                    end else begin
                        r_state <= ST_INS_CMP;
                    end
                end
                ST_INS_CMP: begin
                    if (brk_val > r_v) begin
                        r_pos   <= pos_m1;
                        r_state <= ST_INS_RD;
                    end else begin
                        r_nb    <= r_nb + 1'b1;
                        r_state <= ST_BK_NEXT;
                    end
                end
                ST_BK_NEXT: begin
                    if (!last_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_BK_RD;
                    end else if (r_nb == '0) begin
                        r_eta   <= '0;
                        r_inf   <= 1'b0;
                        r_j     <= '0;
                        r_state <= ST_OUT_RD;
                    end else begin
                        r_state <= ST_B;
                    end
                end
                ST_B:  r_state <= ST_B2;
                ST_B2: begin
                    r_b     <= hlels_pkg::qsat(r_mul_p);
                    r_state <= ST_H;
                end
                ST_H:  r_state <= ST_H2;
                ST_H2: begin
                    r_h     <= hlels_pkg::qsat(r_mul_p);
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_start <= brk_val >>> 1;
                    r_j     <= '0;
                    r_sum   <= '0;
                    r_state <= ST_IN_RD;
                end
                // Indicators at half the first breakpoint
                ST_IN_RD:  r_state <= ST_IN_MUL;
                ST_IN_MUL: begin
                    r_f     <= r_ex_rdata.score;
                    r_d     <= r_ex_rdata.delta;
                    r_state <= ST_IN_UPD;
                end
                ST_IN_UPD: begin
                    if (init_ind) begin
                        r_sum <= r_sum + 39'(r_d);
                    end
                    if (last_j) begin
                        r_state <= ST_RHO;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_IN_RD;
                    end
                end
                ST_RHO:  r_state <= ST_RHO2;
                ST_RHO2: begin
                    r_rho   <= rho_init;
                    r_sup   <= sup_init;
                    r_i     <= '0;
                    r_prev  <= '0;
                    r_eta   <= '0;
                    r_inf   <= 1'b0;
                    r_state <= ST_W_CHK;
                end
                // Breakpoint walk
                ST_W_CHK: begin
                    if (!r_sup[31]) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_prev <= r_rho;
                        if (r_i >= r_nb) begin
                            r_inf   <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_W_HV;
                        end
                    end
                end
                ST_W_HV: begin
                    r_hv    <= brk_val;
                    r_eta   <= brk_val;
                    r_k     <= brk_idx;
                    r_state <= ST_W_EX;
                end
                ST_W_EX: begin
                    r_f     <= r_ex_rdata.score;
                    r_d     <= r_ex_rdata.delta;
                    r_ind   <= r_ex_rdata.ind;
                    r_state <= ST_W_UPD;
                end
                ST_W_UPD: begin
                    r_rho   <= rho_step;
                    r_i     <= i_p1;
                    r_state <= (i_p1 < r_nb) ? ST_W_NXT : ST_W_SUP;
                end
                ST_W_NXT: begin
                    if (brk_val == r_hv) begin
                        r_k     <= brk_idx;
                        r_state <= ST_W_EX;
                    end else begin
                        r_state <= ST_W_SUP;
                    end
                end
                ST_W_SUP:  r_state <= ST_W_SUP2;
                ST_W_SUP2: begin
                    r_sup   <= sup_walk;
                    r_state <= ST_W_CHK;
                end
                // Cap by the previous rho over h
                ST_FIN: begin
                    if (r_prev > 0 && r_h > 0) begin
                        r_dvd   <= {1'b0, r_prev[30:0], 16'h0};
                        r_rem   <= '0;
                        r_dvs   <= r_h;
                        r_dcnt  <= 6'(DW - 1);
                        r_final <= 1'b1;
                        r_state <= ST_DIV;
                    end else begin
                        r_j     <= '0;
                        r_state <= ST_OUT_RD;
                    end
                end
                ST_FIN2: begin
                    if (r_inf || (r_eta > $signed(q_sat))) begin
                        r_eta <= q_sat;
                        r_inf <= 1'b0;
                    end
                    r_j     <= '0;
                    r_state <= ST_OUT_RD;
                end
                // Result delivery
                ST_OUT_RD: r_state <= ST_OUT_LD;
                ST_OUT_LD: begin
                    r_o_idx     <= hlels_pkg::IDX_W'(r_j[AW-1:0]);
                    r_o_ind     <= r_ex_rdata.ind;
                    r_o_step    <= r_inf ? hlels_pkg::Q_MAX : r_eta;
                    r_o_inf     <= r_inf;
                    r_o_last    <= last_j;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT_WT;
                end
                ST_OUT_WT: begin
                    if (out_fire) begin
                        r_out_valid <= 1'b0;
                        if (last_j) begin
                            r_count <= '0;
                            r_nb    <= '0;
                            r_dot   <= '0;
                            r_norm  <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_OUT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.example_index = r_o_idx;
    assign o_out.indicator_out = r_o_ind;
    assign o_out.step_size     = r_o_step;
    assign o_out.step_infinite = r_o_inf;
    assign o_out.result_last   = r_o_last;

    // Checks
    `HLELS_ASSERT_NOW(a_no_in_during_out, i_clk, i_rst_n, r_out_valid, !i_in.ready, "input taken while a result is pending")
    `HLELS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_EXAMPLES), "example count beyond capacity")
    `HLELS_ASSERT_NOW(a_nb_bound, i_clk, i_rst_n, 1'b1, r_nb <= r_count, "more breakpoints than examples")
    `HLELS_ASSERT_NEXT(a_run_cleared, i_clk, i_rst_n, out_fire && r_o_last, r_count == '0 && r_dot == '0 && r_norm == '0, "run state not cleared after last result")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the hinge-loss exact line search core.
`timescale 1ns / 1ps
module testbench;
    import hlels_pkg::*;

    typedef struct {
        bit                    func;
        logic signed [Q_W-1:0] dir_elem;
        logic signed [Q_W-1:0] weight_elem;
        logic signed [Q_W-1:0] score;
        logic signed [Q_W-1:0] score_delta;
        bit                    indicator_in;
        bit                    last;
    } t_item;

    typedef struct {
        logic [IDX_W-1:0]      example_index;
        bit                    indicator_out;
        logic signed [Q_W-1:0] step_size;
        bit                    step_infinite;
        bit                    result_last;
    } t_step_result;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint ONE     = 64'sd65536;
    localparam int     N_EX    = MAX_EXAMPLES_DEF;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0] cfg_data;

    hlels_in_if  in_ch ();
    hlels_out_if out_ch ();

    hinge_loss_exact_line_search_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Stimulus and expectation stores
    t_item        pending_items[$];
    t_step_result expected_steps[$];
    int           n_queued;
    int           n_taken;
    int           n_errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           send_hold;

    // Predictor state
    longint lambda_q, scale_q, dot_sum, norm_sum;
    longint score_mem[N_EX];
    longint delta_mem[N_EX];
    bit     flag_mem[N_EX];
    int     n_stored;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint clamp32(longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint qprod(longint a, longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic longint add_clamp64(longint a, longint b);
        if (b > 0 && a > S64_MAX - b) return S64_MAX;
        if (b < 0 && a < S64_MIN - b) return S64_MIN;
        return a + b;
    endfunction

    // Breakpoint search over the stored examples; queues one result per example
    task automatic search_step();
        longint       bval[N_EX];
        int           bidx[N_EX];
        int           nb, i, j, k;
        longint       q, v, b, h, start, sum, rho, sup, prev, hv, stp, prop, eta;
        int           x;
        bit           unbounded;
        t_step_result r;
        nb = 0;
        eta = 0;
        unbounded = 0;
        for (j = 0; j < n_stored; j++) begin
            if (delta_mem[j] != 0) begin
                q = clamp32(((ONE - score_mem[j]) * ONE) / delta_mem[j]);
                if (q > 0) begin
                    bval[nb] = q;
                    bidx[nb] = j;
                    nb++;
                end
            end
        end
        // ascending order, ties keep example order
        for (i = 1; i < nb; i++) begin
            v = bval[i];
            x = bidx[i];
            j = i;
            while (j > 0 && bval[j-1] > v) begin
                bval[j] = bval[j-1];
                bidx[j] = bidx[j-1];
                j--;
            end
            bval[j] = v;
            bidx[j] = x;
        end
        if (nb > 0) begin
            b = qprod(lambda_q, clamp32(dot_sum >>> 16));
            h = qprod(lambda_q, clamp32(norm_sum >>> 16));
            start = bval[0] >>> 1;
            sum = 0;
            prev = 0;
            for (j = 0; j < n_stored; j++) begin
                flag_mem[j] = (score_mem[j] + ((start * delta_mem[j]) >>> 16)) < ONE;
                if (flag_mem[j]) sum += delta_mem[j];
            end
            rho = clamp32(qprod(scale_q, clamp32(sum)) - b);
            sup = clamp32(-rho);
            i = 0;
            while (sup < 0) begin
                prev = rho;
                if (i >= nb) begin
                    unbounded = 1;
                    break;
                end
                hv = bval[i];
                eta = hv;
                while (i < nb && bval[i] == hv) begin
                    k = bidx[i];
                    stp = qprod(scale_q, delta_mem[k]);
                    rho = flag_mem[k] ? clamp32(rho - stp) : clamp32(rho + stp);
                    flag_mem[k] = !flag_mem[k];
                    i++;
                end
                sup = clamp32(qprod(hv, h) - rho);
            end
            if (prev > 0 && h > 0) begin
                prop = clamp32((prev * ONE) / h);
                if (unbounded || eta > prop) begin
                    eta = prop;
                    unbounded = 0;
                end
            end
        end
        for (j = 0; j < n_stored; j++) begin
            r.example_index = j[IDX_W-1:0];
            r.indicator_out = flag_mem[j];
            r.step_size     = unbounded ? Q_MAX : eta[Q_W-1:0];
            r.step_infinite = unbounded;
            r.result_last   = (j + 1 == n_stored);
            expected_steps.push_back(r);
        end
        n_stored = 0;
        dot_sum = 0;
        norm_sum = 0;
    endtask

    task automatic absorb_item(t_item it);
        longint p, w;
        if (!it.func) begin
            p = it.dir_elem;
            w = it.weight_elem;
            dot_sum  = add_clamp64(dot_sum, p * w);
            norm_sum = add_clamp64(norm_sum, p * p);
        end else begin
            if (n_stored < N_EX) begin
                score_mem[n_stored] = it.score;
                delta_mem[n_stored] = it.score_delta;
                flag_mem[n_stored]  = it.indicator_in;
                n_stored++;
            end
            if (it.last) search_step();
        end
    endtask

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Driver: next transfer is loaded only when the current one completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_items.size() != 0 && !send_hold
                && $urandom_range(99) >= send_idle_pct) begin
                t_item it;
                it = pending_items.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.func         <= it.func;
                in_ch.dir_elem     <= it.dir_elem;
                in_ch.weight_elem  <= it.weight_elem;
                in_ch.score        <= it.score;
                in_ch.score_delta  <= it.score_delta;
                in_ch.indicator_in <= it.indicator_in;
                in_ch.last         <= it.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else          out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Input monitor feeds the predictor on each accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            t_item it;
            it.func         = in_ch.func;
            it.dir_elem     = in_ch.dir_elem;
            it.weight_elem  = in_ch.weight_elem;
            it.score        = in_ch.score;
            it.score_delta  = in_ch.score_delta;
            it.indicator_in = in_ch.indicator_in;
            it.last         = in_ch.last;
            absorb_item(it);
            n_taken++;
        end
    end

    // Output monitor: compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_steps.size() == 0) begin
                report($sformatf("unexpected result index %0d", out_ch.example_index));
            end else begin
                t_step_result e;
                e = expected_steps.pop_front();
                if (out_ch.example_index !== e.example_index)
                    report($sformatf("index got %0d exp %0d",
                                     out_ch.example_index, e.example_index));
                if (out_ch.indicator_out !== e.indicator_out)
                    report($sformatf("indicator idx %0d got %b exp %b", e.example_index,
                                     out_ch.indicator_out, e.indicator_out));
                if (out_ch.step_size !== e.step_size)
                    report($sformatf("step idx %0d got %h exp %h", e.example_index,
                                     out_ch.step_size, e.step_size));
                if (out_ch.step_infinite !== e.step_infinite)
                    report($sformatf("infinite idx %0d got %b exp %b", e.example_index,
                                     out_ch.step_infinite, e.step_infinite));
                if (out_ch.result_last !== e.result_last)
                    report($sformatf("last flag idx %0d got %b exp %b", e.example_index,
                                     out_ch.result_last, e.result_last));
            end
        end
    end

    task automatic push_item(bit func, logic [31:0] p, logic [31:0] w, logic [31:0] f,
                             logic [31:0] df, bit ind, bit last);
        t_item it;
        it.func = func;
        it.dir_elem = p;
        it.weight_elem = w;
        it.score = f;
        it.score_delta = df;
        it.indicator_in = ind;
        it.last = last;
        pending_items.push_back(it);
        n_queued++;
    endtask

    // Mostly within +/-span, sometimes any 32-bit pattern
    function automatic logic [31:0] rand_q(int unsigned span, logic [31:0] center);
        if ($urandom_range(9) == 0) return $urandom();
        return center + $urandom_range(2 * span) - span;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || n_taken != n_queued
               || expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == REG_LAMBDA) lambda_q = val;
        else                   scale_q  = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One search run: weight pairs then examples, last one flagged
    task automatic random_run(int n_ex, int n_w);
        for (int k = 0; k < n_w; k++)
            push_item(1'b0, rand_q(32'h0004_0000, 0), rand_q(32'h0004_0000, 0),
                      $urandom(), $urandom(), $urandom_range(1), $urandom_range(1));
        for (int k = 0; k < n_ex; k++)
            push_item(1'b1, $urandom(), $urandom(),
                      rand_q(32'h0002_0000, 32'h0001_0000),
                      ($urandom_range(9) == 0) ? 32'h0 : rand_q(32'h0002_0000, 0),
                      $urandom_range(1), k == n_ex - 1);
    endtask

    task automatic random_phase(int n_items);
        int cnt, ne, nw;
        cnt = 0;
        while (cnt < n_items) begin
            ne = $urandom_range(1, 6);
            nw = $urandom_range(0, 4);
            random_run(ne, nw);
            cnt += ne + nw;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.dir_elem = '0;
        in_ch.weight_elem = '0;
        in_ch.score = '0;
        in_ch.score_delta = '0;
        in_ch.indicator_in = 1'b0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        n_queued = 0;
        n_taken = 0;
        n_errors = 0;
        send_hold = 0;
        send_idle_pct = 20;
        recv_idle_pct = 82;
        lambda_q = RST_LAMBDA;
        scale_q = RST_LOSS_SCALE;
        dot_sum = 0;
        norm_sum = 0;
        n_stored = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No breakpoints: indicators pass through, eta zero
        push_item(1'b0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_0000, 32'h0, 1, 0);
        push_item(1'b1, 0, 0, 32'h7FFF_FFFF, 32'h0, 0, 1);
        // Field extremes; last bit on a weight item is ignored
        push_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
        push_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        push_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        push_item(1'b1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
        // Typical run with one negative breakpoint
        push_item(1'b0, 32'h0000_8000, 32'h0002_0000, 0, 0, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_0000, 32'h0001_0000, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_8000, 32'hFFFF_0000, 1, 0);
        push_item(1'b1, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 1);
        drain();

        // Zero lambda gives zero h; max loss scale
        write_reg(REG_LAMBDA, '0);
        write_reg(REG_LOSS_SCALE, {REG_W{1'b1}});
        push_item(1'b0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_0000, 32'h0001_0000, 0, 0);
        push_item(1'b1, 0, 0, 32'hFFFF_0000, 32'h0002_0000, 1, 1);
        drain();

        // Max lambda, zero loss scale: subgradient at zero negative
        write_reg(REG_LAMBDA, {REG_W{1'b1}});
        write_reg(REG_LOSS_SCALE, '0);
        push_item(1'b0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_0000, 32'h0001_0000, 0, 0);
        push_item(1'b1, 0, 0, 32'h0000_4000, 32'h0000_8000, 1, 1);
        drain();

        // Random, sender mostly busy and receiver heavily stalled
        write_reg(REG_LAMBDA, $urandom_range(32'h0000_4000, 32'h0002_0000));
        write_reg(REG_LOSS_SCALE, $urandom_range(32'h0000_4000, 32'h0002_0000));
        random_phase(20);
        while (pending_items.size() != 0) @(posedge i_clk);
        // hold the sender with items queued until every outstanding result is back
        send_hold = 1;
        random_phase(5);
        while (n_taken + pending_items.size() != n_queued || expected_steps.size() != 0)
            @(posedge i_clk);
        send_hold = 0;
        drain();

        send_idle_pct = 82;
        recv_idle_pct = 20;
        write_reg(REG_LAMBDA, $urandom_range(32'h0000_0100, 32'h0001_0000));
        write_reg(REG_LOSS_SCALE, $urandom());
        random_phase(12);
        drain();

        // No idling; one run overflowing the example store
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LAMBDA, RST_LAMBDA);
        write_reg(REG_LOSS_SCALE, RST_LOSS_SCALE);
        random_run(N_EX + 2, 3);
        random_phase(3);
        drain();

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
